// ----- src/htbk_pkg.sv -----
// Package: item types, operation and result codes, cell control struct.
`timescale 1ns / 1ps

package htbk_pkg;

    localparam int VALUE_BITS        = 6;
    localparam int RESULT_COUNT_BITS = 32;

    // Operation codes (mode field)
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_TOP    = 2'd2;
    localparam logic [1:0] MODE_BOTTOM = 2'd3;

    // Result kind codes
    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_TOP    = 2'd1;
    localparam logic [1:0] KIND_BOTTOM = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [VALUE_BITS-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [VALUE_BITS-1:0]        result_value;
        logic [RESULT_COUNT_BITS-1:0] result_count;
        logic                         last;
    } t_out_item;

    // Control shared by every ranking cell
    typedef struct packed {
        logic clear;       // drop held and passed entries
        logic insert;      // compare incoming entry, keep the better one
        logic shift;       // take the held entry of the next cell
        logic descending;  // larger counts rank first
    } t_cell_ctl;

endpackage

// ----- src/htbk_cell.sv -----
// One ranking cell: holds one ranked entry and passes the displaced one on.
`timescale 1ns / 1ps

module htbk_cell #(
    parameter int VAL_BITS   = 6,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  htbk_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_fwd_valid,
    input  logic [VAL_BITS-1:0]   i_fwd_value,
    input  logic [COUNT_BITS-1:0] i_fwd_count,
    input  logic                  i_nb_valid,
    input  logic [VAL_BITS-1:0]   i_nb_value,
    input  logic [COUNT_BITS-1:0] i_nb_count,
    output logic                  o_held_valid,
    output logic [VAL_BITS-1:0]   o_held_value,
    output logic [COUNT_BITS-1:0] o_held_count,
    output logic                  o_fwd_valid,
    output logic [VAL_BITS-1:0]   o_fwd_value,
    output logic [COUNT_BITS-1:0] o_fwd_count
);

    logic                  r_held_valid, n_held_valid;
    logic [VAL_BITS-1:0]   r_held_value, n_held_value;
    logic [COUNT_BITS-1:0] r_held_count, n_held_count;
    logic                  r_fwd_valid, n_fwd_valid;
    logic [VAL_BITS-1:0]   r_fwd_value, n_fwd_value;
    logic [COUNT_BITS-1:0] r_fwd_count, n_fwd_count;
    logic                  w_cnt_better;
    logic                  w_better;

    // Full key: count by direction, then lower value wins a tie
    assign w_cnt_better = i_ctl.descending ? (i_fwd_count > r_held_count)
                                           : (i_fwd_count < r_held_count);
    assign w_better = i_fwd_valid && (!r_held_valid || w_cnt_better ||
                      ((i_fwd_count == r_held_count) && (i_fwd_value < r_held_value)));

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_value = r_held_value;
        n_held_count = r_held_count;
        n_fwd_valid  = r_fwd_valid;
        n_fwd_value  = r_fwd_value;
        n_fwd_count  = r_fwd_count;
        if (i_ctl.clear) begin
            n_held_valid = 1'b0;
            n_fwd_valid  = 1'b0;
        end else if (i_ctl.shift) begin
            n_held_valid = i_nb_valid;
            n_held_value = i_nb_value;
            n_held_count = i_nb_count;
            n_fwd_valid  = 1'b0;
        end else if (i_ctl.insert) begin
            if (w_better) begin
                n_held_valid = 1'b1;
                n_held_value = i_fwd_value;
                n_held_count = i_fwd_count;
                n_fwd_valid  = r_held_valid;
                n_fwd_value  = r_held_value;
                n_fwd_count  = r_held_count;
            end else begin
                n_fwd_valid = i_fwd_valid;
                n_fwd_value = i_fwd_value;
                n_fwd_count = i_fwd_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_fwd_valid  <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_fwd_valid  <= n_fwd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_value <= n_held_value;
        r_held_count <= n_held_count;
        r_fwd_value  <= n_fwd_value;
        r_fwd_count  <= n_fwd_count;
    end

    assign o_held_valid = r_held_valid;
    assign o_held_value = r_held_value;
    assign o_held_count = r_held_count;
    assign o_fwd_valid  = r_fwd_valid;
    assign o_fwd_value  = r_fwd_value;
    assign o_fwd_count  = r_fwd_count;

endmodule

// ----- src/htbk_bins.sv -----
// Bin count memory with registered read, plus per-bin seen flags.
`timescale 1ns / 1ps

module htbk_bins #(
    parameter int NUM_BINS   = 64,
    parameter int COUNT_BITS = 32,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [COUNT_BITS-1:0] o_rd_count,
    output logic                  o_rd_seen,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_count
);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_seen;
    logic [COUNT_BITS-1:0] r_rd_count;
    logic                  r_rd_seen;

    // Counts stay undefined until written; seen flags mask them.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_count;
        end
        if (i_rd_en) begin
            r_rd_count <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_seen[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_seen <= r_seen[i_rd_addr];
            end
        end
    end

    assign o_rd_count = r_rd_count;
    assign o_rd_seen  = r_rd_seen;

endmodule

// ----- src/histogram_top_bottom_k.sv -----
// Top level: bounded histogram with add, query and top/bottom ranking reports.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// in        in   i_in_valid / o_in_ready  i_in_item  (mode, sample_value)
// out       out  o_out_valid / i_out_ready o_out_item (kind, result_value,
//                                                      result_count, last)
//
// Adds enter one per cycle while no report runs; each add or query goes through
// a two-stage read-modify-write on the count memory, with forwarding for
// back-to-back adds to the same bin. The second stage writes a query answer
// into the output register; a query waits while another query is in the
// second stage, and while the output register is full and not being taken.
// A report sweeps the memory through the cell chain, then emits one result
// per cycle as the output side takes them.
// Synchronous active-low reset clears the seen flags directly; no sweep.
// A stalled output holds a query item off input, and holds a report's emission.

module histogram_top_bottom_k #(
    parameter int NUM_BINS   = 64,
    parameter int COUNT_BITS = 32,
    parameter int RANK_DEPTH = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  htbk_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output htbk_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int RW = $clog2(RANK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Input decode
    logic          w_in_query;
    logic          w_in_report;
    logic          w_in_table;
    logic [AW-1:0] w_in_addr;
    logic          w_accept;
    logic          w_out_free;

    // Second stage of add / query
    logic                                r_p_valid;
    logic                                r_p_add;
    logic                                r_p_table;
    logic                                r_p_fwd;
    logic [AW-1:0]                       r_p_addr;
    logic [htbk_pkg::VALUE_BITS-1:0]     r_p_value;
    logic [COUNT_BITS-1:0]               r_last_wdata;
    logic                                w_p_query;
    logic [COUNT_BITS-1:0]               w_base;
    logic [COUNT_BITS-1:0]               w_inc;
    logic                                w_wr_en;

    // Memory read port
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [COUNT_BITS-1:0] w_rd_count;
    logic                  w_rd_seen;

    // Report sweep
    logic          r_desc;
    logic [AW-1:0] r_scan;
    logic          r_cand_valid;
    logic [AW-1:0] r_cand_addr;
    logic [RW-1:0] r_drain;

    // Cell chain: link[k] feeds cell k, cell k drives link[k+1]
    htbk_pkg::t_cell_ctl   w_ctl;
    logic                  w_link_valid [RANK_DEPTH+1];
    logic [AW-1:0]         w_link_value [RANK_DEPTH+1];
    logic [COUNT_BITS-1:0] w_link_count [RANK_DEPTH+1];
    logic                  w_held_valid [RANK_DEPTH];
    logic [AW-1:0]         w_held_value [RANK_DEPTH];
    logic [COUNT_BITS-1:0] w_held_count [RANK_DEPTH];
    logic                  w_nb_valid   [RANK_DEPTH];
    logic [AW-1:0]         w_nb_value   [RANK_DEPTH];
    logic [COUNT_BITS-1:0] w_nb_count   [RANK_DEPTH];

    // Output register
    logic                r_out_valid;
    htbk_pkg::t_out_item r_out;
    logic                w_emit;
    logic                w_emit_last;

    assign w_in_query  = (i_in_item.mode == htbk_pkg::MODE_QUERY);
    assign w_in_report = (i_in_item.mode == htbk_pkg::MODE_TOP) ||
                         (i_in_item.mode == htbk_pkg::MODE_BOTTOM);
    assign w_in_table  = (32'(i_in_item.sample_value) < 32'(NUM_BINS));
    assign w_in_addr   = AW'(i_in_item.sample_value);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_p_query   = r_p_valid && !r_p_add;

    // A query needs the output register free when its answer lands.
    assign o_in_ready = (r_state == S_IDLE) &&
                        (!w_in_query || (!w_p_query && w_out_free));
    assign w_accept   = i_in_valid && o_in_ready;

    // Count base: forwarded from the add just written, else memory if seen
    assign w_base  = r_p_fwd ? r_last_wdata : (w_rd_seen ? w_rd_count : '0);
    assign w_inc   = (&w_base) ? w_base : w_base + COUNT_BITS'(1);
    assign w_wr_en = r_p_valid && r_p_add && r_p_table;

    assign w_rd_en   = (w_accept && !w_in_report) || (r_state == S_SCAN);
    assign w_rd_addr = (r_state == S_SCAN) ? r_scan : w_in_addr;

    htbk_bins #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW)
    ) u_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_count (w_rd_count),
        .o_rd_seen  (w_rd_seen),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_p_addr),
        .i_wr_count (w_inc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_accept && !w_in_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_add   <= (i_in_item.mode == htbk_pkg::MODE_ADD);
            r_p_table <= w_in_table;
            r_p_addr  <= w_in_addr;
            r_p_value <= i_in_item.sample_value;
            // Read of a bin that the second stage is writing right now
            r_p_fwd   <= w_wr_en && (r_p_addr == w_in_addr);
        end
        if (w_wr_en) begin
            r_last_wdata <= w_inc;
        end
    end

    // Cell chain control
    always_comb begin
        w_ctl            = '0;
        w_ctl.descending = r_desc;
        w_ctl.clear      = w_accept && w_in_report;
        w_ctl.insert     = (r_state == S_SCAN) || (r_state == S_DRAIN);
        w_ctl.shift      = w_emit;
    end

    // Candidate from the sweep: one bin per cycle, bubbles for unseen bins
    assign w_link_valid[0] = r_cand_valid && w_rd_seen;
    assign w_link_value[0] = r_cand_addr;
    assign w_link_count[0] = w_rd_count;

    for (genvar k = 0; k < RANK_DEPTH; k++) begin : g_cell
        if (k == RANK_DEPTH - 1) begin : g_end
            assign w_nb_valid[k] = 1'b0;
            assign w_nb_value[k] = '0;
            assign w_nb_count[k] = '0;
        end else begin : g_mid
            assign w_nb_valid[k] = w_held_valid[k+1];
            assign w_nb_value[k] = w_held_value[k+1];
            assign w_nb_count[k] = w_held_count[k+1];
        end

        htbk_cell #(
            .VAL_BITS   (AW),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_fwd_valid  (w_link_valid[k]),
            .i_fwd_value  (w_link_value[k]),
            .i_fwd_count  (w_link_count[k]),
            .i_nb_valid   (w_nb_valid[k]),
            .i_nb_value   (w_nb_value[k]),
            .i_nb_count   (w_nb_count[k]),
            .o_held_valid (w_held_valid[k]),
            .o_held_value (w_held_value[k]),
            .o_held_count (w_held_count[k]),
            .o_fwd_valid  (w_link_valid[k+1]),
            .o_fwd_value  (w_link_value[k+1]),
            .o_fwd_count  (w_link_count[k+1])
        );
    end

    // Emission reads cell 0 and shifts the chain toward it
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_emit_last = !w_held_valid[0] || !w_nb_valid[0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_in_report) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan == AW'(NUM_BINS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cand_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cand_valid <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_report) begin
            r_desc <= (i_in_item.mode == htbk_pkg::MODE_TOP);
            r_scan <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan <= r_scan + AW'(1);
        end
        r_cand_addr <= r_scan;
        if (r_state == S_SCAN) begin
            // last candidate still needs its memory read and a pass through the chain
            r_drain <= RW'(RANK_DEPTH - 1);
        end else if (r_state == S_DRAIN) begin
            r_drain <= r_drain - RW'(1);
        end
    end

    // Output register: query answers and report entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_p_query || w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_query) begin
            r_out.kind         <= htbk_pkg::KIND_QUERY;
            r_out.result_value <= r_p_value;
            r_out.result_count <= r_p_table ?
                                  htbk_pkg::RESULT_COUNT_BITS'(w_base) : '0;
            r_out.last         <= 1'b1;
        end else if (w_emit) begin
            if (!w_held_valid[0]) begin
                r_out.kind         <= htbk_pkg::KIND_NONE;
                r_out.result_value <= '0;
                r_out.result_count <= '0;
            end else begin
                r_out.kind         <= r_desc ? htbk_pkg::KIND_TOP : htbk_pkg::KIND_BOTTOM;
                r_out.result_value <= htbk_pkg::VALUE_BITS'(w_held_value[0]);
                r_out.result_count <= htbk_pkg::RESULT_COUNT_BITS'(w_held_count[0]);
            end
            r_out.last <= w_emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // A query answer never lands on a result still waiting in the output register.
    a_query_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_query |-> !r_out_valid)
        else $error("query answer would overwrite a pending result");

    // An empty report is always a single, final result.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == htbk_pkg::KIND_NONE)) |-> o_out_item.last)
        else $error("empty report result without last");

    // An accepted report starts the sweep on the next cycle.
    a_report_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         ((i_in_item.mode == htbk_pkg::MODE_TOP) ||
          (i_in_item.mode == htbk_pkg::MODE_BOTTOM))) |=> (r_state == S_SCAN))
        else $error("report accepted but sweep not started");

    // No item is taken while the previous report is still being swept or sent.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_DRAIN) || (r_state == S_EMIT)) |->
        !o_in_ready)
        else $error("input accepted during a report");
`endif

endmodule
